FILE: sv/pbpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbpq_pkg: power button press qualifier shared definitions
// Field widths, register indexes, reset values and the edge/level flag bundle.
// ----------------------------------------------------------------------------
package pbpq_pkg;

  localparam int SampleBitsDefault = 16;

  // port field widths
  localparam int SampleW  = 16;
  localparam int SpeedW   = 21;
  localparam int EdgeW    = 13;
  localparam int BandW    = 12;
  localparam int ShortW   = 10;
  localparam int LongW    = 12;
  localparam int SpdThrW  = 20;
  localparam int HoldW    = 16;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 20;
  localparam int MelW     = 2;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegEdge     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegBand     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegShort    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegLong     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSpeedThr = 3'd4;

  // register reset values
  localparam logic [EdgeW-1:0]   EdgeReset     = 13'd900;
  localparam logic [BandW-1:0]   BandReset     = 12'd200;
  localparam logic [ShortW-1:0]  ShortReset    = 10'd50;
  localparam logic [LongW-1:0]   LongReset     = 12'd300;
  localparam logic [SpdThrW-1:0] SpeedThrReset = 20'd100;

  typedef enum logic [MelW-1:0] {
    MelNone            = 2'd0,
    MelDisconnect      = 2'd1,
    MelErrorDisconnect = 2'd2
  } melody_e;

  // per-sample classification handed from the feature logic to the control
  typedef struct packed {
    logic steady;     // |s - last| < band
    logic rising;     // s - last > edge
    logic falling;    // last - s > edge
    logic low;        // s < baseline + edge/2
    logic high;       // s > baseline + 1.5 edge
    logic spd_above;  // |speed| > threshold
    logic spd_below;  // |speed| < threshold
  } feat_t;

endpackage

FILE: sv/power_button_press_qualifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_button_press_qualifier: button hold / release shutdown qualifier
// Tracks the unpressed baseline of the button sense voltage, times presses
// and decides when to request power-off, with motor speed gating.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one tick request: sample_i and
//   motor_speed_i. Output channel (out_valid_o/out_ready_i) returns exactly one
//   result per request, in order: keep_power_o, beep_stop_o, melody_o, armed_o.
//   A request passes one input register, then the classification, control
//   decision and baseline average resolve combinationally into the result
//   register, which drives out_valid_o (the divide by ten is a reciprocal
//   multiply in that logic). Throughput is one request per cycle while the
//   receiver keeps out_ready_i high.
//   When the receiver stalls, the result register holds and the input register
//   still takes one more request; in_ready_o drops only when both are full.
//   Reset (rst_ni low, asynchronous) clears all tracking state and loads the
//   register defaults; the first request after reset only primes the stored
//   last sample. Configuration writes (cfg_we_i, cfg_index_i, cfg_wdata_i) take
//   effect at the clock edge; indexes above 4 are ignored. Write only while idle.
// ----------------------------------------------------------------------------
module power_button_press_qualifier #(
  parameter int SampleBits = pbpq_pkg::SampleBitsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pbpq_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [pbpq_pkg::CfgDataW-1:0]       cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [pbpq_pkg::SampleW-1:0]        sample_i,
  input  logic signed [pbpq_pkg::SpeedW-1:0]  motor_speed_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                keep_power_o,
  output logic                                beep_stop_o,
  output logic [pbpq_pkg::MelW-1:0]           melody_o,
  output logic                                armed_o
);

  localparam int DivN    = SampleBits + 4;   // 9*b + s + 5 fits here
  localparam int DivK    = DivN + 4;         // reciprocal shift, exact for x < 2^DivN
  localparam int RecipW  = DivK - 2;
  localparam longint unsigned RecipL = ((64'd1 << DivK) + 64'd9) / 64'd10;
  localparam logic [RecipW-1:0] Recip = RecipW'(RecipL);
  localparam int ProdW   = DivN + RecipW;

  // configuration
  logic [pbpq_pkg::EdgeW-1:0]   edge_q;
  logic [pbpq_pkg::BandW-1:0]   band_q;
  logic [pbpq_pkg::ShortW-1:0]  short_q;
  logic [pbpq_pkg::LongW-1:0]   long_q;
  logic [pbpq_pkg::SpdThrW-1:0] spd_thr_q;

  // input stage
  logic                               s1_valid_q, s1_valid_d;
  logic [SampleBits-1:0]              s1_smp_q;
  logic signed [pbpq_pkg::SpeedW-1:0] s1_speed_q;
  logic [pbpq_pkg::SampleW+SampleBits-1:0] smp_ext;
  logic                               accept;
  logic                               advance;

  // tracking state
  logic [SampleBits-1:0]      last_q, last_d;
  logic                       last_valid_q, last_valid_d;
  logic [SampleBits-1:0]      base_q, base_d;
  logic                       base_valid_q, base_valid_d;
  logic [pbpq_pkg::HoldW-1:0] hold_q, hold_d, hold_inc;
  logic                       armed_q, armed_d;
  logic                       forced_q, forced_d;

  // result stage
  logic                       out_valid_q, out_valid_d;
  logic                       keep_q, keep_d;
  logic                       bstop_q, bstop_d;
  pbpq_pkg::melody_e          mel_q, mel_d;
  logic                       arm_out_q;

  pbpq_pkg::feat_t            feat;
  logic [DivN-1:0]            avg_sum;
  logic [ProdW-1:0]           avg_prod;
  logic [SampleBits-1:0]      avg;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;
  assign s1_valid_d = accept || (s1_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !out_ready_i);

  // only the low SampleBits of the port are meaningful
  assign smp_ext = {{SampleBits{1'b0}}, sample_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_q    <= pbpq_pkg::EdgeReset;
      band_q    <= pbpq_pkg::BandReset;
      short_q   <= pbpq_pkg::ShortReset;
      long_q    <= pbpq_pkg::LongReset;
      spd_thr_q <= pbpq_pkg::SpeedThrReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pbpq_pkg::RegEdge:     edge_q    <= cfg_wdata_i[pbpq_pkg::EdgeW-1:0];
        pbpq_pkg::RegBand:     band_q    <= cfg_wdata_i[pbpq_pkg::BandW-1:0];
        pbpq_pkg::RegShort:    short_q   <= cfg_wdata_i[pbpq_pkg::ShortW-1:0];
        pbpq_pkg::RegLong:     long_q    <= cfg_wdata_i[pbpq_pkg::LongW-1:0];
        pbpq_pkg::RegSpeedThr: spd_thr_q <= cfg_wdata_i[pbpq_pkg::SpdThrW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_smp_q   <= smp_ext[SampleBits-1:0];
      s1_speed_q <= motor_speed_i;
    end
  end

  pbpq_feat #(
    .SampleBits (SampleBits)
  ) u_feat (
    .smp_i      (s1_smp_q),
    .last_i     (last_q),
    .base_i     (base_q),
    .speed_i    (s1_speed_q),
    .edge_thr_i (edge_q),
    .band_i     (band_q),
    .spd_thr_i  (spd_thr_q),
    .feat_o     (feat)
  );

  // drift average: (9*b + s + 5) / 10 by reciprocal multiply
  assign avg_sum  = DivN'({base_q, 3'b000}) + DivN'(base_q) + DivN'(s1_smp_q) + DivN'(5);
  assign avg_prod = ProdW'(avg_sum) * ProdW'(Recip);
  assign avg      = avg_prod[DivK +: SampleBits];

  assign hold_inc = (hold_q == '1) ? hold_q : hold_q + 1'b1;

  always_comb begin
    last_d       = last_q;
    last_valid_d = last_valid_q;
    base_d       = base_q;
    base_valid_d = base_valid_q;
    hold_d       = hold_q;
    armed_d      = armed_q;
    forced_d     = forced_q;
    keep_d       = 1'b1;
    bstop_d      = 1'b0;
    mel_d        = pbpq_pkg::MelNone;
    if (advance) begin
      last_d       = s1_smp_q;
      last_valid_d = 1'b1;
      if (last_valid_q) begin
        priority if (!base_valid_q) begin
          if (feat.steady) begin
            base_d       = s1_smp_q;
            base_valid_d = 1'b1;
          end
        end else if (armed_q) begin
          // speed cancels an unforced arm; release requests power-off
          priority if (!forced_q && feat.spd_above) begin
            armed_d = 1'b0;
            hold_d  = '0;
            bstop_d = 1'b1;
          end else if (feat.falling || feat.low) begin
            hold_d  = hold_inc;
            bstop_d = 1'b1;
            keep_d  = 1'b0;
          end else begin
          end
        end else if (hold_q == '0) begin
          priority if (feat.rising) begin
            hold_d = pbpq_pkg::HoldW'(1);
          end else if (feat.steady && feat.low) begin
            base_d = avg;
          end else begin
          end
        end else if (feat.high) begin
          hold_d = hold_inc;
          if (hold_inc > pbpq_pkg::HoldW'(short_q)) begin
            priority if (feat.spd_below) begin
              armed_d = 1'b1;
              hold_d  = '0;
              mel_d   = pbpq_pkg::MelDisconnect;
            end else if (hold_inc > pbpq_pkg::HoldW'(long_q)) begin
              armed_d  = 1'b1;
              forced_d = 1'b1;
              hold_d   = '0;
              mel_d    = pbpq_pkg::MelErrorDisconnect;
            end else begin
            end
          end
        end else begin
          hold_d  = '0;
          bstop_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      last_q       <= '0;
      last_valid_q <= 1'b0;
      base_q       <= '0;
      base_valid_q <= 1'b0;
      hold_q       <= '0;
      armed_q      <= 1'b0;
      forced_q     <= 1'b0;
    end else begin
      s1_valid_q   <= s1_valid_d;
      out_valid_q  <= out_valid_d;
      last_q       <= last_d;
      last_valid_q <= last_valid_d;
      base_q       <= base_d;
      base_valid_q <= base_valid_d;
      hold_q       <= hold_d;
      armed_q      <= armed_d;
      forced_q     <= forced_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      keep_q    <= keep_d;
      bstop_q   <= bstop_d;
      mel_q     <= mel_d;
      arm_out_q <= armed_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign keep_power_o = keep_q;
  assign beep_stop_o  = bstop_q;
  assign melody_o     = mel_q;
  assign armed_o      = arm_out_q;

  // a baseline only exists once a sample has primed the tracker
  a_base_needs_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    base_valid_q |-> last_valid_q)
    else $error("baseline valid without a primed last sample");

  // a forced shutdown can never be cancelled
  a_forced_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    forced_q |-> armed_q)
    else $error("forced shutdown without arm");

  // power-off is only requested while armed
  a_off_when_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !keep_power_o |-> armed_o)
    else $error("power-off result while not armed");

  // a melody request comes only with a fresh arm
  a_melody_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (melody_o != pbpq_pkg::MelNone) |-> armed_o && keep_power_o)
    else $error("melody request without arming");

  // a held request in the input stage is not dropped
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q && $stable(s1_smp_q))
    else $error("input stage lost a pending request");

endmodule

FILE: sv/pbpq_feat.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbpq_feat: sample and speed classification
// Edge, steadiness and level compares against last sample and baseline, plus
// the motor speed magnitude compare. Half and 1.5x thresholds use doubled units.
// ----------------------------------------------------------------------------
module pbpq_feat #(
  parameter int SampleBits = pbpq_pkg::SampleBitsDefault
) (
  input  logic [SampleBits-1:0]              smp_i,
  input  logic [SampleBits-1:0]              last_i,
  input  logic [SampleBits-1:0]              base_i,
  input  logic signed [pbpq_pkg::SpeedW-1:0] speed_i,
  input  logic [pbpq_pkg::EdgeW-1:0]         edge_thr_i,
  input  logic [pbpq_pkg::BandW-1:0]         band_i,
  input  logic [pbpq_pkg::SpdThrW-1:0]       spd_thr_i,
  output pbpq_pkg::feat_t                    feat_o
);

  localparam int DW = SampleBits + 3;  // signed difference, holds edge too
  localparam int CW = SampleBits + 3;  // doubled-unit level compares

  logic signed [DW-1:0]           diff;
  logic signed [DW-1:0]           ndiff;
  logic [DW-1:0]                  adiff;
  logic signed [DW-1:0]           edge_s;
  logic [CW-1:0]                  s2;
  logic [CW-1:0]                  b2;
  logic [CW-1:0]                  edge_w;
  logic [CW-1:0]                  edge3_w;
  logic [pbpq_pkg::SpeedW-1:0]    mag;
  logic [pbpq_pkg::SpeedW-1:0]    thr_w;

  assign diff    = $signed(DW'(smp_i)) - $signed(DW'(last_i));
  assign ndiff   = -diff;
  assign adiff   = diff[DW-1] ? $unsigned(ndiff) : $unsigned(diff);
  assign edge_s  = $signed(DW'(edge_thr_i));

  assign s2      = CW'({smp_i, 1'b0});
  assign b2      = CW'({base_i, 1'b0});
  assign edge_w  = CW'(edge_thr_i);
  assign edge3_w = CW'({edge_thr_i, 1'b0}) + edge_w;

  assign mag     = speed_i[pbpq_pkg::SpeedW-1] ? $unsigned(-speed_i) : $unsigned(speed_i);
  assign thr_w   = pbpq_pkg::SpeedW'(spd_thr_i);

  always_comb begin
    feat_o.steady    = adiff < DW'(band_i);
    feat_o.rising    = diff > edge_s;
    feat_o.falling   = ndiff > edge_s;
    feat_o.low       = s2 < (b2 + edge_w);
    feat_o.high      = s2 > (b2 + edge3_w);
    feat_o.spd_above = mag > thr_w;
    feat_o.spd_below = mag < thr_w;
  end

endmodule
